>>> design/spstat_pkg.sv
// Shared widths and stage payload types for the spectrum peak statistics unit.
package spstat_pkg;

   localparam int MZ_W      = 23;   // peak and precursor m/z
   localparam int INT_W     = 32;   // peak intensity
   localparam int SUM_W     = 44;   // saturating intensity sums
   localparam int CNT_OUT_W = 13;   // peak counts on the result channel

   // Largest value of a saturating intensity sum
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // Spectrum totals captured on the last peak
   typedef struct packed {
      logic [SUM_W-1:0]     total;
      logic [SUM_W-1:0]     fore_acc;
      logic [INT_W-1:0]     max_fore;
      logic [SUM_W-1:0]     back_acc;
      logic [INT_W-1:0]     max_back;
      logic [INT_W-1:0]     base;
      logic [INT_W-1:0]     second;
      logic [CNT_OUT_W-1:0] count_all;
      logic [CNT_OUT_W-1:0] count_fore;
   } snap_type;

   // Totals with the largest peak of each side taken off
   typedef struct packed {
      logic [SUM_W-1:0]     total;
      logic [SUM_W-1:0]     fore_sum;
      logic [SUM_W-1:0]     back_sum;
      logic [INT_W-1:0]     base;
      logic [INT_W-1:0]     second;
      logic [CNT_OUT_W-1:0] count_all;
      logic [CNT_OUT_W-1:0] count_fore;
   } diff_type;

endpackage

>>> design/spstat_req_if.sv
// Peak channel interface: valid/ready handshake carrying one peak per transfer.
interface spstat_req_if import spstat_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [MZ_W-1:0]  peak_mz;
   logic [INT_W-1:0] peak_intensity;
   logic             last_peak;

   modport source (output valid, output peak_mz, output peak_intensity, output last_peak,
                   input ready);
   modport sink   (input valid, input peak_mz, input peak_intensity, input last_peak,
                   output ready);

endinterface

>>> design/spstat_rsp_if.sv
// Result channel interface: valid/ready handshake carrying one spectrum summary.
interface spstat_rsp_if import spstat_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [SUM_W-1:0]     total_intensity;
   logic [SUM_W-1:0]     fore_sum;
   logic [SUM_W-1:0]     back_sum;
   logic [INT_W-1:0]     base_peak;
   logic [INT_W-1:0]     second_peak;
   logic                 singly_charged;
   logic [CNT_OUT_W-1:0] peak_count;
   logic [CNT_OUT_W-1:0] kept_count;

   modport source (output valid, output total_intensity, output fore_sum, output back_sum,
                   output base_peak, output second_peak, output singly_charged,
                   output peak_count, output kept_count, input ready);
   modport sink   (input valid, input total_intensity, input fore_sum, input back_sum,
                   input base_peak, input second_peak, input singly_charged,
                   input peak_count, input kept_count, output ready);

endinterface

>>> design/spstat_accum.sv
// Peak input register, per-spectrum accumulators and the end-of-spectrum snapshot.
module spstat_accum import spstat_pkg::*; #(
   parameter int MAX_PEAKS        = 4096,
   parameter int MZ_FRACTION_BITS = 10
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [MZ_W-1:0] csr_wdata,
   spstat_req_if.sink      req_ch,
   output logic            snap_valid,
   input  logic            snap_ready,
   output snap_type        snap
);

   localparam int CNT_W = $clog2(MAX_PEAKS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PEAKS);
   // Half of one m/z unit, and the mask that drops the fraction bits
   localparam logic [MZ_W:0] MZ_HALF     = ((MZ_W+1)'(1) << MZ_FRACTION_BITS) >> 1;
   localparam logic [MZ_W:0] MZ_INT_MASK = ~(((MZ_W+1)'(1) << MZ_FRACTION_BITS) - 1'b1);

   logic [MZ_W-1:0]  precursor_ff;

   logic             in_valid_ff;
   logic             in_fore_ff, in_fore_in;
   logic             in_last_ff;
   logic [INT_W-1:0] in_int_ff;

   logic [SUM_W-1:0] total_ff, total_in;
   logic [SUM_W-1:0] fore_ff, fore_in;
   logic [SUM_W-1:0] back_ff, back_in;
   logic [INT_W-1:0] max_fore_ff, max_fore_in;
   logic [INT_W-1:0] max_back_ff, max_back_in;
   logic [INT_W-1:0] max_seen_ff, max_seen_in;
   logic [INT_W-1:0] second_ff, second_in;
   logic [CNT_W-1:0] count_all_ff, count_all_in;
   logic [CNT_W-1:0] count_fore_ff, count_fore_in;

   logic             snap_valid_ff;
   snap_type         snap_ff, snap_in;

   logic             acc_fire;
   logic [MZ_W:0]    mz_rounded;
   logic [SUM_W:0]   total_sum, side_sum;
   logic [SUM_W-1:0] side_sat;

   // Accumulate stage advances unless a last peak meets a held snapshot
   assign acc_fire     = in_valid_ff && (!in_last_ff || !snap_valid_ff || snap_ready);
   assign req_ch.ready = !in_valid_ff || acc_fire;
   assign snap_valid   = snap_valid_ff;
   assign snap         = snap_ff;

   // Round m/z to the nearest unit (halves up) and classify against the precursor
   assign mz_rounded = ({1'b0, req_ch.peak_mz} + MZ_HALF) & MZ_INT_MASK;
   assign in_fore_in = mz_rounded <= {1'b0, precursor_ff};

   // Saturating sums and running maxima
   always_comb begin
      total_sum = {1'b0, total_ff} + (SUM_W+1)'(in_int_ff);
      side_sum  = (in_fore_ff ? {1'b0, fore_ff} : {1'b0, back_ff}) + (SUM_W+1)'(in_int_ff);
      side_sat  = side_sum[SUM_W] ? SUM_MAX : side_sum[SUM_W-1:0];

      total_in      = total_sum[SUM_W] ? SUM_MAX : total_sum[SUM_W-1:0];
      fore_in       = fore_ff;
      back_in       = back_ff;
      max_fore_in   = max_fore_ff;
      max_back_in   = max_back_ff;
      count_fore_in = count_fore_ff;
      if (in_fore_ff) begin
         fore_in = side_sat;
         if (in_int_ff > max_fore_ff) max_fore_in = in_int_ff;
         count_fore_in = (count_fore_ff >= CNT_MAX) ? CNT_MAX : count_fore_ff + 1'b1;
      end else begin
         back_in = side_sat;
         if (in_int_ff > max_back_ff) max_back_in = in_int_ff;
      end

      // Base and second peak; a tie with the base is ignored
      max_seen_in = max_seen_ff;
      second_in   = second_ff;
      if (in_int_ff > max_seen_ff) begin
         second_in   = max_seen_ff;
         max_seen_in = in_int_ff;
      end else if (in_int_ff > second_ff && in_int_ff < max_seen_ff) begin
         second_in = in_int_ff;
      end

      count_all_in = (count_all_ff >= CNT_MAX) ? CNT_MAX : count_all_ff + 1'b1;

      snap_in.total      = total_in;
      snap_in.fore_acc   = fore_in;
      snap_in.max_fore   = max_fore_in;
      snap_in.back_acc   = back_in;
      snap_in.max_back   = max_back_in;
      snap_in.base       = max_seen_in;
      snap_in.second     = second_in;
      snap_in.count_all  = CNT_OUT_W'(count_all_in);
      snap_in.count_fore = CNT_OUT_W'(count_fore_in);
   end

   // Control and accumulator state; the accumulators are cleared after each spectrum
   always_ff @(posedge clock) begin
      if (reset) begin
         precursor_ff  <= '0;
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         total_ff      <= '0;
         fore_ff       <= '0;
         back_ff       <= '0;
         max_fore_ff   <= '0;
         max_back_ff   <= '0;
         max_seen_ff   <= '0;
         second_ff     <= '0;
         count_all_ff  <= '0;
         count_fore_ff <= '0;
      end else begin
         if (csr_we) precursor_ff <= csr_wdata;
         if (req_ch.ready) in_valid_ff <= req_ch.valid;
         if (acc_fire && in_last_ff) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_ready) begin
            snap_valid_ff <= 1'b0;
         end
         if (acc_fire) begin
            if (in_last_ff) begin
               total_ff      <= '0;
               fore_ff       <= '0;
               back_ff       <= '0;
               max_fore_ff   <= '0;
               max_back_ff   <= '0;
               max_seen_ff   <= '0;
               second_ff     <= '0;
               count_all_ff  <= '0;
               count_fore_ff <= '0;
            end else begin
               total_ff      <= total_in;
               fore_ff       <= fore_in;
               back_ff       <= back_in;
               max_fore_ff   <= max_fore_in;
               max_back_ff   <= max_back_in;
               max_seen_ff   <= max_seen_in;
               second_ff     <= second_in;
               count_all_ff  <= count_all_in;
               count_fore_ff <= count_fore_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_fore_ff <= in_fore_in;
         in_last_ff <= req_ch.last_peak;
         in_int_ff  <= req_ch.peak_intensity;
      end
      if (acc_fire && in_last_ff) snap_ff <= snap_in;
   end

endmodule

>>> design/spectrum_peak_statistics_unit.sv
// Spectrum peak statistics unit: top level with result finishing stages.
//
// Peaks of one spectrum arrive on req_ch, one per transfer; last_peak marks
// the final peak. The precursor m/z is written through csr_we/csr_wdata while
// the unit is idle. For each spectrum one summary leaves on rsp_ch: total
// intensity, fore and back sums with each side's largest peak removed, base
// and second peak, the singly-charged flag and the peak counts.
// Throughput is one peak per cycle; req_ch.ready stays high while results
// flow. On its way to rsp_ch the summary passes the input register, the
// accumulator/snapshot register and the side subtraction register, then the
// compare into the output register.
// Reset (synchronous) clears the precursor, all accumulators and all valids.
// When the receiver stalls, the summary holds in the output register and the
// two stages behind it fill; peaks of the next spectrum are still taken until
// its last peak finds the snapshot stage occupied, and only then does
// req_ch.ready drop.
module spectrum_peak_statistics_unit import spstat_pkg::*; #(
   parameter int MAX_PEAKS        = 4096,
   parameter int MZ_FRACTION_BITS = 10
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [MZ_W-1:0] csr_wdata,
   spstat_req_if.sink      req_ch,
   spstat_rsp_if.source    rsp_ch
);

   logic     snap_valid, snap_ready;
   snap_type snap;

   logic     diff_valid_ff;
   diff_type diff_ff, diff_in;

   logic                 out_valid_ff;
   logic                 out_load;
   logic [SUM_W-1:0]     out_total_ff;
   logic [SUM_W-1:0]     out_fore_ff;
   logic [SUM_W-1:0]     out_back_ff;
   logic [INT_W-1:0]     out_base_ff;
   logic [INT_W-1:0]     out_second_ff;
   logic                 out_single_ff, out_single_in;
   logic [CNT_OUT_W-1:0] out_count_ff;
   logic [CNT_OUT_W-1:0] out_kept_ff, out_kept_in;

   spstat_accum #(
      .MAX_PEAKS        (MAX_PEAKS),
      .MZ_FRACTION_BITS (MZ_FRACTION_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_ch     (req_ch),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // Stage handshakes
   assign out_load   = diff_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign snap_ready = !diff_valid_ff || out_load;

   // Remove the largest peak of each side; sums never fall below their maxima
   always_comb begin
      diff_in.total      = snap.total;
      diff_in.fore_sum   = snap.fore_acc - SUM_W'(snap.max_fore);
      diff_in.back_sum   = snap.back_acc - SUM_W'(snap.max_back);
      diff_in.base       = snap.base;
      diff_in.second     = snap.second;
      diff_in.count_all  = snap.count_all;
      diff_in.count_fore = snap.count_fore;
   end

   // Singly charged when fore exceeds eight times back
   assign out_single_in = {3'b000, diff_ff.fore_sum} > {diff_ff.back_sum, 3'b000};
   assign out_kept_in   = out_single_in ? diff_ff.count_fore : diff_ff.count_all;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (snap_ready) diff_valid_ff <= snap_valid;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (snap_ready && snap_valid) diff_ff <= diff_in;
      if (out_load) begin
         out_total_ff  <= diff_ff.total;
         out_fore_ff   <= diff_ff.fore_sum;
         out_back_ff   <= diff_ff.back_sum;
         out_base_ff   <= diff_ff.base;
         out_second_ff <= diff_ff.second;
         out_single_ff <= out_single_in;
         out_count_ff  <= diff_ff.count_all;
         out_kept_ff   <= out_kept_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.total_intensity = out_total_ff;
   assign rsp_ch.fore_sum        = out_fore_ff;
   assign rsp_ch.back_sum        = out_back_ff;
   assign rsp_ch.base_peak       = out_base_ff;
   assign rsp_ch.second_peak     = out_second_ff;
   assign rsp_ch.singly_charged  = out_single_ff;
   assign rsp_ch.peak_count      = out_count_ff;
   assign rsp_ch.kept_count      = out_kept_ff;

endmodule

>>> dv/tb_top.sv
// Testbench for the spectrum peak statistics unit: random and directed peaks, predicted summaries.
`timescale 1ns / 1ps

module tb_top import spstat_pkg::*; ();

   localparam int MZ_FRAC        = 10;
   localparam int MAX_PEAKS      = 4096;
   localparam int MZ_MAX         = (1 << MZ_W) - 1;
   localparam int MZ_HALF        = (1 << MZ_FRAC) >> 1;
   localparam int DIR_PREC       = 500 << MZ_FRAC;   // precursor for the directed spectra
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [MZ_W-1:0]  mz;
      logic [INT_W-1:0] intensity;
      logic             last;
   } peak_type;

   typedef struct packed {
      logic [SUM_W-1:0]     total;
      logic [SUM_W-1:0]     fore;
      logic [SUM_W-1:0]     back;
      logic [INT_W-1:0]     base;
      logic [INT_W-1:0]     runner;
      logic                 singly;
      logic [CNT_OUT_W-1:0] count;
      logic [CNT_OUT_W-1:0] kept;
   } summary_type;

   logic            clock;
   logic            reset;
   logic            csr_we;
   logic [MZ_W-1:0] csr_wdata;

   spstat_req_if req_ch ();
   spstat_rsp_if rsp_ch ();

   spectrum_peak_statistics_unit #(
      .MAX_PEAKS        (MAX_PEAKS),
      .MZ_FRACTION_BITS (MZ_FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // Pending peaks and predicted summaries
   peak_type    peak_queue[$];
   summary_type expected_summaries[$];
   int          peaks_queued = 0;
   int          peaks_taken  = 0;
   int          mismatches   = 0;
   int          quiet_cycles = 0;

   // Traffic shaping
   bit       no_idle     = 1'b0;
   int       hold_asked  = 0;
   int       hold_served = 0;
   int       hold_left   = 0;

   // Predictor state
   logic [MZ_W-1:0]      precursor_reg = '0;
   logic [SUM_W-1:0]     run_total = '0;
   logic [SUM_W-1:0]     run_fore  = '0;
   logic [SUM_W-1:0]     run_back  = '0;
   logic [INT_W-1:0]     top_fore  = '0;
   logic [INT_W-1:0]     top_back  = '0;
   logic [INT_W-1:0]     top_all   = '0;
   logic [INT_W-1:0]     runner_up = '0;
   logic [CNT_OUT_W-1:0] n_all     = '0;
   logic [CNT_OUT_W-1:0] n_fore    = '0;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] acc,
                                                input logic [INT_W-1:0] x);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + (SUM_W+1)'(x);
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function automatic logic [CNT_OUT_W-1:0] count_up(input logic [CNT_OUT_W-1:0] c);
      return (c >= MAX_PEAKS) ? CNT_OUT_W'(MAX_PEAKS) : c + 1'b1;
   endfunction

   // Fold one peak into the running spectrum statistics; returns 1 with the summary on the last
   function automatic bit fold_peak(input peak_type p, output summary_type s);
      logic [31:0]      mz_round;
      logic [SUM_W-1:0] fore_net;
      logic [SUM_W-1:0] back_net;
      logic             is_fore;
      s = '0;
      // nearest integer m/z, halves upwards, back in fixed point
      mz_round = ((32'(p.mz) + MZ_HALF) >> MZ_FRAC) << MZ_FRAC;
      is_fore  = mz_round <= 32'(precursor_reg);
      run_total = sum_sat(run_total, p.intensity);
      if (is_fore) begin
         run_fore = sum_sat(run_fore, p.intensity);
         if (p.intensity > top_fore) top_fore = p.intensity;
         n_fore = count_up(n_fore);
      end else begin
         run_back = sum_sat(run_back, p.intensity);
         if (p.intensity > top_back) top_back = p.intensity;
      end
      // base and second peak, a tie with the base is ignored
      if (p.intensity > top_all) begin
         runner_up = top_all;
         top_all   = p.intensity;
      end else if (p.intensity > runner_up && p.intensity < top_all) begin
         runner_up = p.intensity;
      end
      n_all = count_up(n_all);
      if (!p.last) return 1'b0;

      fore_net = run_fore - top_fore;
      back_net = run_back - top_back;
      s.total  = run_total;
      s.fore   = fore_net;
      s.back   = back_net;
      s.base   = top_all;
      s.runner = runner_up;
      s.singly = {3'b000, fore_net} > {back_net, 3'b000};
      s.count  = n_all;
      s.kept   = s.singly ? n_fore : n_all;
      // fresh spectrum
      run_total = '0;
      run_fore  = '0;
      run_back  = '0;
      top_fore  = '0;
      top_back  = '0;
      top_all   = '0;
      runner_up = '0;
      n_all     = '0;
      n_fore    = '0;
      return 1'b1;
   endfunction

   // Peak driver: holds an offer until its transfer, gaps only between peaks
   always @(posedge clock) begin : drive_peaks
      peak_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (peak_queue.size() != 0 && (no_idle || $urandom_range(99, 0) >= 25)) begin
            nxt = peak_queue.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.peak_mz        <= nxt.mz;
            req_ch.peak_intensity <= nxt.intensity;
            req_ch.last_peak      <= nxt.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Summary receiver: random back-pressure, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(99, 0) >= 25);
      end
   end

   // Monitor: predict on peak transfers, check on summary transfers, watchdog
   always @(posedge clock) begin : watch_channels
      peak_type    p;
      summary_type got;
      summary_type want;
      if (!reset) begin
         quiet_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            quiet_cycles = 0;
            peaks_taken++;
            p = '{req_ch.peak_mz, req_ch.peak_intensity, req_ch.last_peak};
            if (fold_peak(p, want)) expected_summaries = {expected_summaries, want};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            quiet_cycles = 0;
            got = '{rsp_ch.total_intensity, rsp_ch.fore_sum, rsp_ch.back_sum,
                    rsp_ch.base_peak, rsp_ch.second_peak, rsp_ch.singly_charged,
                    rsp_ch.peak_count, rsp_ch.kept_count};
            if (expected_summaries.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: summary with none outstanding: total=%h", $realtime, got.total);
            end else begin
               want = expected_summaries.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: summary mismatch", $realtime);
                     $display("  exp total=%h fore=%h back=%h base=%h second=%h sc=%b n=%0d kept=%0d",
                              want.total, want.fore, want.back, want.base, want.runner,
                              want.singly, want.count, want.kept);
                     $display("  got total=%h fore=%h back=%h base=%h second=%h sc=%b n=%0d kept=%0d",
                              got.total, got.fore, got.back, got.base, got.runner,
                              got.singly, got.count, got.kept);
                  end
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic push_peak(input int mz, input logic [INT_W-1:0] inten,
                            input logic last);
      peak_type item;
      item = '{MZ_W'(mz), inten, last};
      peak_queue = {peak_queue, item};
      peaks_queued++;
   endtask

   // Wait until every peak is taken and every summary is back, then let the pipe settle
   task automatic wait_drained();
      while (peaks_taken != peaks_queued || expected_summaries.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_precursor(input int v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= MZ_W'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      precursor_reg = MZ_W'(v);
   endtask

   // One random spectrum, m/z spread over the range, near the precursor and on rounding edges
   task automatic queue_spectrum(input int len);
      int               lean;
      int               mzi;
      int               base;
      logic [INT_W-1:0] prev;
      logic [INT_W-1:0] val;
      lean = $urandom_range(2, 0);
      prev = $urandom;
      base = int'((precursor_reg >> MZ_FRAC) << MZ_FRAC);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(3, 0))
            0:       mzi = int'($urandom_range(MZ_MAX, 0));
            1:       mzi = int'(precursor_reg) + int'($urandom_range(4096, 0)) - 2048;
            2:       mzi = base + MZ_HALF - 1 + int'($urandom_range(1, 0));
            default: mzi = base - MZ_HALF - int'($urandom_range(1, 0));
         endcase
         if (mzi < 0) mzi = 0;
         if (mzi > MZ_MAX) mzi = MZ_MAX;
         case ($urandom_range(9, 0))
            0:       val = '0;
            1:       val = '1;
            2:       val = prev;                      // repeat, exercises ties
            3, 4:    val = $urandom_range(1000, 0);
            default: val = $urandom;
         endcase
         // tilt one side low so both outcomes of the charge test turn up
         if ((lean == 1 && mzi > int'(precursor_reg)) || (lean == 2 && mzi <= int'(precursor_reg)))
            val = val >> $urandom_range(31, 12);
         push_peak(mzi, val, k == len - 1);
         prev = val;
      end
   endtask

   task automatic run_phase(input int prec, input int items);
      int start;
      int len;
      wait_drained();
      write_precursor(prec);
      start = peaks_queued;
      while (peaks_queued - start < items) begin
         len = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         queue_spectrum(len);
      end
   endtask

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.peak_mz        = '0;
      req_ch.peak_intensity = '0;
      req_ch.last_peak      = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_we                = 1'b0;
      csr_wdata             = '0;
      reset                 = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed spectra around a precursor on an integer m/z
      write_precursor(DIR_PREC);
      // lone peak at m/z zero, full-scale intensity, no back peaks
      push_peak(0, '1, 1'b1);
      // fore remainder one above eight times the back remainder
      push_peak(DIR_PREC - 1024, 1000, 1'b0);
      push_peak(DIR_PREC, 81, 1'b0);
      push_peak(DIR_PREC + 1024, 500, 1'b0);
      push_peak(DIR_PREC + 2048, 10, 1'b1);
      // fore remainder exactly eight times back: not singly charged
      push_peak(DIR_PREC - 1024, 1000, 1'b0);
      push_peak(DIR_PREC, 80, 1'b0);
      push_peak(DIR_PREC + 1024, 500, 1'b0);
      push_peak(DIR_PREC + 2048, 10, 1'b1);
      // second-peak rule, all back at top m/z: rise, tie with base, in between, zero, full scale
      push_peak(MZ_MAX, 50, 1'b0);
      push_peak(MZ_MAX, 70, 1'b0);
      push_peak(MZ_MAX, 70, 1'b0);
      push_peak(MZ_MAX, 60, 1'b0);
      push_peak(MZ_MAX, 0, 1'b0);
      push_peak(MZ_MAX, '1, 1'b1);
      // rounding edges either side of the precursor
      push_peak(DIR_PREC + MZ_HALF - 1, 5, 1'b0);
      push_peak(DIR_PREC + MZ_HALF, 6, 1'b0);
      push_peak(DIR_PREC - MZ_HALF, 7, 1'b0);
      push_peak(DIR_PREC - MZ_HALF - 1, 0, 1'b0);
      push_peak(MZ_MAX, 1, 1'b1);

      // Register extremes
      run_phase(0, 200);
      run_phase(MZ_MAX, 200);

      run_phase(int'($urandom_range(MZ_MAX, 0)), 200);
      run_phase(int'($urandom_range(MZ_MAX, 0)), 200);

      // Receiver holds off while short spectra keep coming with no gaps, then a longer stretch, also with no gaps
      run_phase(int'($urandom_range(MZ_MAX, 0)), 0);
      no_idle = 1'b1;
      hold_asked++;
      repeat (30) queue_spectrum($urandom_range(3, 1));
      run_phase(int'($urandom_range(MZ_MAX, 0)), 250);
      wait_drained();
      no_idle = 1'b0;

      run_phase(int'($urandom_range(MZ_MAX, 0)), 200);
      run_phase(int'($urandom_range(MZ_MAX, 0)), 150);
      run_phase(int'($urandom_range(MZ_MAX, 0)), 100);
      wait_drained();

      if (mismatches == 0 && expected_summaries.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
